@@ rtl/tft_window_address_engine_core_macros.svh @@
// Assertion macros shared by the window address engine RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TFT_WINDOW_ADDRESS_ENGINE_CORE_MACROS_SVH
`define TFT_WINDOW_ADDRESS_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TFTWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TFTWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tftwa_pkg.sv @@
// Package for the TFT window address engine: command codes, register
// indexes, reset values and widths. No dependencies.
`timescale 1ns / 1ps

package tftwa_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int PIX_W          = 10;
  localparam int BYTE_W         = 8;
  localparam int BLEFT_W        = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BYTES = 2'd2;

  localparam logic [PIX_W-1:0] MAX_X_RST      = 10'd239;
  localparam logic [PIX_W-1:0] MAX_Y_RST      = 10'd319;
  localparam logic [1:0]       ADDR_BYTES_RST = 2'd2;

  localparam logic [BYTE_W-1:0] CMD_NOP     = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_SWRESET = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_INVOFF  = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_INVON   = 8'h21;
  localparam logic [BYTE_W-1:0] CMD_DISPOFF = 8'h28;
  localparam logic [BYTE_W-1:0] CMD_DISPON  = 8'h29;
  localparam logic [BYTE_W-1:0] CMD_CASET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_PASET   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_RAMWR   = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_MADCTL  = 8'h36;

  localparam int MAD_SWAP_BIT = 5;
  localparam int MAD_MCOL_BIT = 6;
  localparam int MAD_MROW_BIT = 7;

  typedef struct packed {
    logic              write_valid;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic [BYTE_W-1:0] pixel_value;
    logic              out_of_range;
    logic              display_on;
    logic              display_inverted;
  } tftwa_result_t;

endpackage

@@ rtl/tftwa_ifs.sv @@
// Valid/ready channel interfaces: command/data byte input and pixel write
// result output. Depends on tftwa_pkg.
`timescale 1ns / 1ps

interface tftwa_in_if
  import tftwa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output func, output byte_value, input ready);
  modport sink   (input valid, input func, input byte_value, output ready);
endinterface

interface tftwa_out_if
  import tftwa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;
  logic [BYTE_W-1:0] pixel_value;
  logic              out_of_range;
  logic              display_on;
  logic              display_inverted;

  modport source (output valid, output write_valid, output pixel_x, output pixel_y,
                  output pixel_value, output out_of_range, output display_on,
                  output display_inverted, input ready);
  modport sink   (input valid, input write_valid, input pixel_x, input pixel_y,
                  input pixel_value, input out_of_range, input display_on,
                  input display_inverted, output ready);
endinterface

@@ rtl/tftwa_coord_map.sv @@
// One-axis address mapper: optional mirror, single wrap by lim+1, range check.
// Depends on tftwa_pkg.
`timescale 1ns / 1ps

module tftwa_coord_map
  import tftwa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] coord,
  input  logic                  mirror,
  input  logic [PIX_W-1:0]      lim,
  output logic [PIX_W-1:0]      mapped,
  output logic                  in_range
);

  localparam int CW = (COORD_BITS > PIX_W + 1) ? COORD_BITS : PIX_W + 1;

  logic [CW-1:0] a_ext;
  logic [CW-1:0] lim_ext;
  logic [CW-1:0] lim2_ext;
  logic [CW-1:0] wrapped;
  logic          over;

  assign a_ext    = CW'(coord);
  assign lim_ext  = CW'(lim);
  assign lim2_ext = CW'({lim, 1'b1});
  assign over     = a_ext > lim_ext;
  assign wrapped  = a_ext - lim_ext - CW'(1);

  // mirrored: lim - a, valid only for a <= lim
  // plain: a, or a - (lim + 1) once when above lim
  always_comb begin
    if (mirror) begin
      in_range = !over;
      mapped   = lim - a_ext[PIX_W-1:0];
    end else begin
      in_range = a_ext <= lim2_ext;
      mapped   = over ? wrapped[PIX_W-1:0] : a_ext[PIX_W-1:0];
    end
  end

endmodule

@@ rtl/tft_window_address_engine_core.sv @@
// TFT command and GRAM window address engine, top level.
// Uses tftwa_pkg, tftwa_ifs, tftwa_coord_map and the assertion macro header.
//
// in_ch  : valid/ready channel of bus bytes (func 1 = command, 0 = data).
// out_ch : valid/ready channel, one result per byte: pixel write strobe,
//          mapped x/y, pixel byte, out-of-range flag, display on/invert flags.
// cfg_*  : write port for max_x (0), max_y (1) and addr_bytes (2); write only
//          while no byte is in flight.
// A byte taken on in_ch is registered in the input stage; its result is
// registered in the output stage that drives out_ch. Throughput: one byte
// per cycle while out_ch is not held; command decode, cursor advance and
// the mirror/wrap mapping all sit between the input and result registers.
// Stall: while out_ch is held, the input stage keeps one more byte, then
// in_ch.ready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous): both stages empty, registers back to
// max_x 239, max_y 319, addr_bytes 2, window full-screen, cursor at origin,
// MADCTL bits and display flags cleared, no write stream open.
`timescale 1ns / 1ps

module tft_window_address_engine_core
  import tftwa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tftwa_in_if.sink              in_ch,
  tftwa_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CB = COORD_BITS;

  // configuration
  logic [PIX_W-1:0] max_x_r, max_y_r;
  logic [1:0]       addr_bytes_r;

  // input stage
  logic              s1_valid_r;
  logic              s1_func_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_go;
  logic              in_xfer;

  // engine state
  logic [BYTE_W-1:0]  last_command_r, last_command_nxt;
  logic [BLEFT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic               write_stream_r, write_stream_nxt;
  logic [BYTE_W-1:0]  high_byte_r, high_byte_nxt;
  logic [CB-1:0]      win_sx_r, win_sx_nxt, win_ex_r, win_ex_nxt;
  logic [CB-1:0]      win_sy_r, win_sy_nxt, win_ey_r, win_ey_nxt;
  logic [CB-1:0]      cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic               swap_r, swap_nxt, mcol_r, mcol_nxt, mrow_r, mrow_nxt;
  logic               disp_on_r, disp_on_nxt, disp_inv_r, disp_inv_nxt;

  // output stage
  logic          out_valid_r;
  tftwa_result_t res_r, res_nxt;

  // datapath helpers
  logic [CB-1:0]      ax, ay;
  logic [PIX_W-1:0]   mx, my;
  logic               okx, oky;
  logic [CB:0]        cx_inc, cy_inc;
  logic [2*BYTE_W-1:0] one_wide, two_wide;
  logic [CB-1:0]      coord_one, coord_two;
  logic               is_col;

  assign s1_go        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign ax = swap_r ? cur_y_r : cur_x_r;
  assign ay = swap_r ? cur_x_r : cur_y_r;

  tftwa_coord_map #(.COORD_BITS(CB)) u_map_x (
    .coord    (ax),
    .mirror   (mcol_r),
    .lim      (max_x_r),
    .mapped   (mx),
    .in_range (okx)
  );

  tftwa_coord_map #(.COORD_BITS(CB)) u_map_y (
    .coord    (ay),
    .mirror   (mrow_r),
    .lim      (max_y_r),
    .mapped   (my),
    .in_range (oky)
  );

  assign cx_inc    = {1'b0, cur_x_r} + (CB+1)'(1);
  assign cy_inc    = {1'b0, cur_y_r} + (CB+1)'(1);
  assign one_wide  = {{BYTE_W{1'b0}}, s1_byte_r};
  assign two_wide  = {high_byte_r, s1_byte_r};
  assign coord_one = one_wide[CB-1:0];
  assign coord_two = two_wide[CB-1:0];
  assign is_col    = last_command_r == CMD_CASET;

  always_comb begin
    last_command_nxt = last_command_r;
    bytes_left_nxt   = bytes_left_r;
    write_stream_nxt = write_stream_r;
    high_byte_nxt    = high_byte_r;
    win_sx_nxt       = win_sx_r;
    win_ex_nxt       = win_ex_r;
    win_sy_nxt       = win_sy_r;
    win_ey_nxt       = win_ey_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    swap_nxt         = swap_r;
    mcol_nxt         = mcol_r;
    mrow_nxt         = mrow_r;
    disp_on_nxt      = disp_on_r;
    disp_inv_nxt     = disp_inv_r;
    res_nxt          = '0;

    if (s1_go) begin
      if (s1_func_r) begin
        last_command_nxt = s1_byte_r;
        bytes_left_nxt   = '0;
        write_stream_nxt = 1'b0;
        case (s1_byte_r)
          CMD_NOP, CMD_SWRESET: begin
            last_command_nxt = CMD_NOP;
            high_byte_nxt    = '0;
            win_sx_nxt       = '0;
            win_ex_nxt       = CB'(max_x_r);
            win_sy_nxt       = '0;
            win_ey_nxt       = CB'(max_y_r);
            cur_x_nxt        = '0;
            cur_y_nxt        = '0;
            swap_nxt         = 1'b0;
            mcol_nxt         = 1'b0;
            mrow_nxt         = 1'b0;
            disp_on_nxt      = 1'b0;
            disp_inv_nxt     = 1'b0;
          end
          CMD_INVOFF:  disp_inv_nxt = 1'b0;
          CMD_INVON:   disp_inv_nxt = 1'b1;
          CMD_DISPOFF: disp_on_nxt  = 1'b0;
          CMD_DISPON:  disp_on_nxt  = 1'b1;
          CMD_CASET, CMD_PASET: begin
            bytes_left_nxt = (addr_bytes_r == 2'd1) ? BLEFT_W'(2) : BLEFT_W'(4);
          end
          CMD_RAMWR: begin
            write_stream_nxt = 1'b1;
            cur_x_nxt        = win_sx_r;
            cur_y_nxt        = win_sy_r;
          end
          CMD_MADCTL: bytes_left_nxt = BLEFT_W'(1);
          default: ;
        endcase
      end else if (write_stream_r && last_command_r == CMD_RAMWR) begin
        if (okx && oky) begin
          res_nxt.write_valid = 1'b1;
          res_nxt.pixel_x     = mx;
          res_nxt.pixel_y     = my;
          res_nxt.pixel_value = s1_byte_r;
        end else begin
          res_nxt.out_of_range = 1'b1;
        end
        if (cx_inc > {1'b0, win_ex_r}) begin
          cur_x_nxt = win_sx_r;
          if (cy_inc > {1'b0, win_ey_r}) begin
            cur_y_nxt = win_sy_r;
          end else begin
            cur_y_nxt = cy_inc[CB-1:0];
          end
        end else begin
          cur_x_nxt = cx_inc[CB-1:0];
        end
      end else if (bytes_left_r != '0) begin
        if (last_command_r == CMD_CASET || last_command_r == CMD_PASET) begin
          if (addr_bytes_r == 2'd1) begin
            if (bytes_left_r == BLEFT_W'(2)) begin
              if (is_col) begin
                win_sx_nxt = coord_one;
                cur_x_nxt  = coord_one;
              end else begin
                win_sy_nxt = coord_one;
                cur_y_nxt  = coord_one;
              end
            end else if (bytes_left_r == BLEFT_W'(1)) begin
              if (is_col) win_ex_nxt = coord_one;
              else        win_ey_nxt = coord_one;
            end
          end else begin
            if (bytes_left_r == BLEFT_W'(4) || bytes_left_r == BLEFT_W'(2)) begin
              high_byte_nxt = s1_byte_r;
            end else if (bytes_left_r == BLEFT_W'(3)) begin
              if (is_col) begin
                win_sx_nxt = coord_two;
                cur_x_nxt  = coord_two;
              end else begin
                win_sy_nxt = coord_two;
                cur_y_nxt  = coord_two;
              end
            end else if (bytes_left_r == BLEFT_W'(1)) begin
              if (is_col) win_ex_nxt = coord_two;
              else        win_ey_nxt = coord_two;
            end
          end
        end else if (last_command_r == CMD_MADCTL) begin
          swap_nxt = s1_byte_r[MAD_SWAP_BIT];
          mcol_nxt = s1_byte_r[MAD_MCOL_BIT];
          mrow_nxt = s1_byte_r[MAD_MROW_BIT];
        end
        bytes_left_nxt = bytes_left_r - BLEFT_W'(1);
      end
      res_nxt.display_on       = disp_on_nxt;
      res_nxt.display_inverted = disp_inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r        <= MAX_X_RST;
      max_y_r        <= MAX_Y_RST;
      addr_bytes_r   <= ADDR_BYTES_RST;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      last_command_r <= '0;
      bytes_left_r   <= '0;
      write_stream_r <= 1'b0;
      high_byte_r    <= '0;
      win_sx_r       <= '0;
      win_ex_r       <= CB'(MAX_X_RST);
      win_sy_r       <= '0;
      win_ey_r       <= CB'(MAX_Y_RST);
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      swap_r         <= 1'b0;
      mcol_r         <= 1'b0;
      mrow_r         <= 1'b0;
      disp_on_r      <= 1'b0;
      disp_inv_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_X:      max_x_r      <= cfg_data;
          CFG_MAX_Y:      max_y_r      <= cfg_data;
          CFG_ADDR_BYTES: addr_bytes_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      last_command_r <= last_command_nxt;
      bytes_left_r   <= bytes_left_nxt;
      write_stream_r <= write_stream_nxt;
      high_byte_r    <= high_byte_nxt;
      win_sx_r       <= win_sx_nxt;
      win_ex_r       <= win_ex_nxt;
      win_sy_r       <= win_sy_nxt;
      win_ey_r       <= win_ey_nxt;
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      swap_r         <= swap_nxt;
      mcol_r         <= mcol_nxt;
      mrow_r         <= mrow_nxt;
      disp_on_r      <= disp_on_nxt;
      disp_inv_r     <= disp_inv_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= in_ch.func;
      s1_byte_r <= in_ch.byte_value;
    end
    if (s1_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.write_valid      = res_r.write_valid;
  assign out_ch.pixel_x          = res_r.pixel_x;
  assign out_ch.pixel_y          = res_r.pixel_y;
  assign out_ch.pixel_value      = res_r.pixel_value;
  assign out_ch.out_of_range     = res_r.out_of_range;
  assign out_ch.display_on       = res_r.display_on;
  assign out_ch.display_inverted = res_r.display_inverted;

`include "tft_window_address_engine_core_macros.svh"

  `TFTWA_ASSERT_NOW(a_write_not_oor, out_valid_r && res_r.write_valid,
    !res_r.out_of_range, "pixel write flagged out of range")
  `TFTWA_ASSERT_NOW(a_idle_fields_zero, out_valid_r && !res_r.write_valid,
    res_r.pixel_x == '0 && res_r.pixel_y == '0 && res_r.pixel_value == '0,
    "pixel fields not cleared without a write")
  `TFTWA_ASSERT_NOW(a_stream_is_ramwr, write_stream_r,
    last_command_r == CMD_RAMWR, "write stream open without memory write command")
  `TFTWA_ASSERT_NEXT(a_stream_no_params, s1_go && s1_func_r,
    !(write_stream_r && bytes_left_r != '0), "write stream with parameters pending")

endmodule
